// ===== src/lci_pkg.sv =====
// Shared constants and types for the line and circle intersection block.
`default_nettype none
package lci_pkg;

   localparam int GUARD_BITS = 15;

   typedef logic [1:0] hit_type;

   localparam hit_type HIT_NONE    = 2'd0;
   localparam hit_type HIT_TANGENT = 2'd1;
   localparam hit_type HIT_SECANT  = 2'd2;

   localparam int LANE_FX = 0;
   localparam int LANE_FY = 1;
   localparam int LANE_HX = 2;
   localparam int LANE_HY = 3;
   localparam int LANES   = 4;

endpackage
`default_nettype wire

// ===== src/lci_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, with remainder.
`default_nettype none
module lci_sqrt_pipe #(
   parameter int IN_W   = 96,
   parameter int OUT_W  = 48,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_value,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [OUT_W-1:0]  out_root,
   output logic [IN_W-1:0]   out_rem,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [0:OUT_W];
   logic [OUT_W-1:0]  root_ff  [0:OUT_W];
   logic [IN_W-1:0]   rem_ff   [0:OUT_W];
   logic [SIDE_W-1:0] side_ff  [0:OUT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      root_ff[0] <= '0;
      rem_ff[0]  <= in_value;
      side_ff[0] <= in_side;
   end

   for (genvar s = 0; s < OUT_W; s++) begin : g_stage
      localparam int B = OUT_W - 1 - s;
      logic [IN_W-1:0] inc;
      logic            take;

      assign inc  = (IN_W'(root_ff[s]) << (B + 1)) | (IN_W'(1) << (2 * B));
      assign take = rem_ff[s] >= inc;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         root_ff[s+1] <= take ? (root_ff[s] | (OUT_W'(1) << B)) : root_ff[s];
         rem_ff[s+1]  <= take ? (rem_ff[s] - inc) : rem_ff[s];
         side_ff[s+1] <= side_ff[s];
      end
   end

   assign out_valid = valid_ff[OUT_W];
   assign out_root  = root_ff[OUT_W];
   assign out_rem   = rem_ff[OUT_W];
   assign out_side  = side_ff[OUT_W];

endmodule
`default_nettype wire

// ===== src/lci_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
`default_nettype none
module lci_div_pipe #(
   parameter int NUM_W  = 100,
   parameter int DEN_W  = 48,
   parameter int Q_W    = 34,
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num [LANES],
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quo [LANES],
   output logic              out_ovf [LANES],
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [0:Q_W];
   logic [DEN_W-1:0]  den_ff   [0:Q_W];
   logic [SIDE_W-1:0] side_ff  [0:Q_W];
   logic [DEN_W-1:0]  rem_ff   [0:Q_W][LANES];
   logic [Q_W-1:0]    low_ff   [0:Q_W][LANES];
   logic [Q_W-1:0]    quo_ff   [0:Q_W][LANES];
   logic              ovf_ff   [0:Q_W][LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_load
      always_ff @(posedge clock) begin
         rem_ff[0][l] <= DEN_W'(in_num[l] >> Q_W);
         low_ff[0][l] <= in_num[l][Q_W-1:0];
         quo_ff[0][l] <= '0;
         ovf_ff[0][l] <= (in_num[l] >> Q_W) >= NUM_W'(in_den);
      end
   end

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int B = Q_W - 1 - s;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         den_ff[s+1]  <= den_ff[s];
         side_ff[s+1] <= side_ff[s];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEN_W:0] trial;
         logic           take;

         assign trial = {rem_ff[s][l], low_ff[s][l][B]};
         assign take  = trial >= {1'b0, den_ff[s]};

         always_ff @(posedge clock) begin
            rem_ff[s+1][l] <= take ? DEN_W'(trial - {1'b0, den_ff[s]}) : DEN_W'(trial);
            low_ff[s+1][l] <= low_ff[s][l];
            quo_ff[s+1][l] <= quo_ff[s][l] | (take ? (Q_W'(1) << B) : '0);
            ovf_ff[s+1][l] <= ovf_ff[s][l];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quo[l] = quo_ff[Q_W][l];
      assign out_ovf[l] = ovf_ff[Q_W][l];
   end

   assign out_valid = valid_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule
`default_nettype wire

// ===== src/line_circle_intersection.sv =====
// Top level: streaming line and circle intersection pipeline.
`default_nettype none
// One request enters per clock whenever start is high; busy never rises. Every request
// gives exactly one response, rsp_valid high for one cycle, after passing through the two
// bit-per-stage square roots and the two bit-per-stage dividers in series. The receiver
// cannot stall, and nothing is lost at full rate.
module line_circle_intersection
   import lci_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_line_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_line_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_line_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_line_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic        [COORD_WIDTH-2:0] req_radius,
   output logic                          rsp_valid,
   output logic        [1:0]             rsp_hit_count,
   output logic signed [COORD_WIDTH-1:0] rsp_point0_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point0_y,
   output logic signed [COORD_WIDTH-1:0] rsp_point1_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point1_y
);

   localparam int W   = COORD_WIDTH;
   localparam int G   = GUARD_BITS;
   localparam int Q   = W + 2;
   localparam int DW  = W + 1;
   localparam int L2W = 2 * W + 2;
   localparam int S1W = L2W + 2 * G;
   localparam int RW  = W + 1 + G;
   localparam int NW  = 2 * W + 4 + G;
   localparam int PW  = 2 * W + 3;
   localparam int XW  = 2 * W - 2;
   localparam int HW  = W - 1;
   localparam int SW  = Q + 3;
   localparam logic [63:0] SMALL = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
   localparam logic [L2W-1:0] SMALL_L = L2W'(SMALL);
   localparam logic [2*Q-1:0] SMALL_D = (2 * Q)'(SMALL);
   localparam logic signed [SW-1:0] OUT_MAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [SW-1:0] OUT_MIN = ~OUT_MAX;

   typedef struct packed {
      logic                 degen;
      logic                 cneg;
      logic [L2W-1:0]       cm;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [W-1:0]  cx;
      logic signed [W-1:0]  cy;
      logic [W-2:0]         r;
   } side_a_type;

   typedef struct packed {
      logic                 degen;
      logic                 cneg;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [W-1:0]  cx;
      logic signed [W-1:0]  cy;
      logic [W-2:0]         r;
      logic [RW-1:0]        root;
   } side_b_type;

   typedef struct packed {
      hit_type              hit;
      logic                 zeroed;
      logic                 cneg;
      logic [Q-1:0]         dm;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [W-1:0]  cx;
      logic signed [W-1:0]  cy;
      logic [RW-1:0]        root;
   } side_c_type;

   typedef struct packed {
      hit_type             hit;
      logic                zeroed;
      logic                fx_neg;
      logic                fy_neg;
      logic                hx_neg;
      logic                hy_neg;
      logic signed [W-1:0] cx;
      logic signed [W-1:0] cy;
   } side_d_type;

   // stage 1: differences
   logic                 v1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, ox1_ff, oy1_ff;
   logic signed [W-1:0]  cx1_ff, cy1_ff;
   logic [W-2:0]         r1_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff <= DW'(req_line_b_x) - DW'(req_line_a_x);
      dy1_ff <= DW'(req_line_b_y) - DW'(req_line_a_y);
      ox1_ff <= DW'(req_center_x) - DW'(req_line_a_x);
      oy1_ff <= DW'(req_center_y) - DW'(req_line_a_y);
      cx1_ff <= req_center_x;
      cy1_ff <= req_center_y;
      r1_ff  <= req_radius;
   end

   // stage 2: squares and cross products
   logic [DW-1:0]        mdx, mdy, mox, moy;
   logic                 v2_ff, n1_ff, n2_ff;
   logic [L2W-1:0]       sqx_ff, sqy_ff, p1_ff, p2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff;
   logic signed [W-1:0]  cx2_ff, cy2_ff;
   logic [W-2:0]         r2_ff;

   assign mdx = dx1_ff[DW-1] ? DW'(-dx1_ff) : DW'(dx1_ff);
   assign mdy = dy1_ff[DW-1] ? DW'(-dy1_ff) : DW'(dy1_ff);
   assign mox = ox1_ff[DW-1] ? DW'(-ox1_ff) : DW'(ox1_ff);
   assign moy = oy1_ff[DW-1] ? DW'(-oy1_ff) : DW'(oy1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff <= L2W'(mdx) * L2W'(mdx);
      sqy_ff <= L2W'(mdy) * L2W'(mdy);
      p1_ff  <= L2W'(mdx) * L2W'(moy);
      p2_ff  <= L2W'(mdy) * L2W'(mox);
      n1_ff  <= dx1_ff[DW-1] ^ oy1_ff[DW-1];
      n2_ff  <= ~(dy1_ff[DW-1] ^ ox1_ff[DW-1]);
      dx2_ff <= dx1_ff;
      dy2_ff <= dy1_ff;
      cx2_ff <= cx1_ff;
      cy2_ff <= cy1_ff;
      r2_ff  <= r1_ff;
   end

   // stage 3: squared length and signed cross magnitude
   logic           v3_ff;
   side_a_type     a3_ff;
   logic [L2W-1:0] len2_ff;
   logic [L2W-1:0] len2_in, cm_in;
   logic           cneg_in;

   assign len2_in = sqx_ff + sqy_ff;

   always_comb begin
      if (n1_ff == n2_ff) begin
         cm_in   = p1_ff + p2_ff;
         cneg_in = n1_ff;
      end else if (p1_ff >= p2_ff) begin
         cm_in   = p1_ff - p2_ff;
         cneg_in = n1_ff;
      end else begin
         cm_in   = p2_ff - p1_ff;
         cneg_in = n2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      len2_ff     <= len2_in;
      a3_ff.degen <= len2_in <= SMALL_L;
      a3_ff.cneg  <= cneg_in;
      a3_ff.cm    <= cm_in;
      a3_ff.dx    <= dx2_ff;
      a3_ff.dy    <= dy2_ff;
      a3_ff.cx    <= cx2_ff;
      a3_ff.cy    <= cy2_ff;
      a3_ff.r     <= r2_ff;
   end

   // line length with guard bits
   logic           sq1_valid;
   logic [RW-1:0]  sq1_root;
   side_a_type     sq1_side;

   lci_sqrt_pipe #(
      .IN_W   (S1W),
      .OUT_W  (RW),
      .SIDE_W ($bits(side_a_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_value  ({len2_ff, {(2 * G){1'b0}}}),
      .in_side   (a3_ff),
      .out_valid (sq1_valid),
      .out_root  (sq1_root),
      .out_rem   (),
      .out_side  (sq1_side)
   );

   // stage 4: distance numerator
   logic          v4_ff;
   logic [NW-1:0] dnum_ff [1];
   side_b_type    b4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= sq1_valid;
      end
   end

   always_ff @(posedge clock) begin
      dnum_ff[0]  <= (NW'(sq1_side.cm) << G) + NW'(sq1_root >> 1);
      b4_ff.degen <= sq1_side.degen;
      b4_ff.cneg  <= sq1_side.cneg;
      b4_ff.dx    <= sq1_side.dx;
      b4_ff.dy    <= sq1_side.dy;
      b4_ff.cx    <= sq1_side.cx;
      b4_ff.cy    <= sq1_side.cy;
      b4_ff.r     <= sq1_side.r;
      b4_ff.root  <= sq1_root;
   end

   logic         dv1_valid;
   logic [Q-1:0] dv1_quo [1];
   logic         dv1_ovf [1];
   side_b_type   dv1_side;

   lci_div_pipe #(
      .NUM_W  (NW),
      .DEN_W  (RW),
      .Q_W    (Q),
      .LANES  (1),
      .SIDE_W ($bits(side_b_type))
   ) u_dist_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (dnum_ff),
      .in_den    (b4_ff.root),
      .in_side   (b4_ff),
      .out_valid (dv1_valid),
      .out_quo   (dv1_quo),
      .out_ovf   (dv1_ovf),
      .out_side  (dv1_side)
   );

   // stage 5: miss test and squares
   logic           v5_ff, miss5_ff;
   logic [Q-1:0]   dm5_ff;
   logic [2*Q-1:0] dm2_ff;
   logic [XW-1:0]  rr5_ff;
   side_b_type     b5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= dv1_valid;
      end
   end

   always_ff @(posedge clock) begin
      miss5_ff <= dv1_ovf[0] | (dv1_quo[0] > (Q'(dv1_side.r) + Q'(1)));
      dm5_ff   <= dv1_quo[0];
      dm2_ff   <= (2 * Q)'(dv1_quo[0]) * (2 * Q)'(dv1_quo[0]);
      rr5_ff   <= XW'(dv1_side.r) * XW'(dv1_side.r);
      b5_ff    <= dv1_side;
   end

   // stage 6: classify and chord argument
   logic           v6_ff;
   logic [XW-1:0]  x6_ff;
   side_c_type     c6_ff;
   logic           zeroed_in;
   logic [Q:0]     near_in;
   hit_type        hit_in;

   assign zeroed_in = dm2_ff <= SMALL_D;
   assign near_in   = (zeroed_in ? '0 : (Q + 1)'(dm5_ff)) + (Q + 1)'(1);

   always_comb begin
      if (b5_ff.degen || miss5_ff) begin
         hit_in = HIT_NONE;
      end else if (near_in < (Q + 1)'(b5_ff.r)) begin
         hit_in = HIT_SECANT;
      end else begin
         hit_in = HIT_TANGENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      x6_ff        <= ((2 * Q)'(rr5_ff) > dm2_ff) ? XW'((2 * Q)'(rr5_ff) - dm2_ff) : '0;
      c6_ff.hit    <= hit_in;
      c6_ff.zeroed <= zeroed_in;
      c6_ff.cneg   <= b5_ff.cneg;
      c6_ff.dm     <= dm5_ff;
      c6_ff.dx     <= b5_ff.dx;
      c6_ff.dy     <= b5_ff.dy;
      c6_ff.cx     <= b5_ff.cx;
      c6_ff.cy     <= b5_ff.cy;
      c6_ff.root   <= b5_ff.root;
   end

   // half chord
   logic          sq2_valid;
   logic [HW-1:0] sq2_root;
   logic [XW-1:0] sq2_rem;
   side_c_type    sq2_side;

   lci_sqrt_pipe #(
      .IN_W   (XW),
      .OUT_W  (HW),
      .SIDE_W ($bits(side_c_type))
   ) u_chord_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_value  (x6_ff),
      .in_side   (c6_ff),
      .out_valid (sq2_valid),
      .out_root  (sq2_root),
      .out_rem   (sq2_rem),
      .out_side  (sq2_side)
   );

   // stage 7: round half chord
   logic       v7_ff;
   logic [Q-1:0] h7_ff;
   side_c_type c7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= sq2_valid;
      end
   end

   always_ff @(posedge clock) begin
      h7_ff <= Q'(sq2_root) + ((sq2_rem > XW'(sq2_root)) ? Q'(1) : Q'(0));
      c7_ff <= sq2_side;
   end

   // stage 8: scale products
   logic          v8_ff;
   logic [PW-1:0] prod8_ff [LANES];
   side_c_type    c8_ff;
   logic [DW-1:0] adx, ady;

   assign adx = c7_ff.dx[DW-1] ? DW'(-c7_ff.dx) : DW'(c7_ff.dx);
   assign ady = c7_ff.dy[DW-1] ? DW'(-c7_ff.dy) : DW'(c7_ff.dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod8_ff[LANE_FX] <= PW'(c7_ff.dm) * PW'(ady);
      prod8_ff[LANE_FY] <= PW'(c7_ff.dm) * PW'(adx);
      prod8_ff[LANE_HX] <= PW'(h7_ff) * PW'(adx);
      prod8_ff[LANE_HY] <= PW'(h7_ff) * PW'(ady);
      c8_ff             <= c7_ff;
   end

   // stage 9: scale numerators
   logic          v9_ff;
   logic [NW-1:0] num9_ff [LANES];
   logic [RW-1:0] root9_ff;
   side_d_type    d9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_num
      always_ff @(posedge clock) begin
         num9_ff[l] <= (NW'(prod8_ff[l]) << G) + NW'(c8_ff.root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      root9_ff      <= c8_ff.root;
      d9_ff.hit     <= c8_ff.hit;
      d9_ff.zeroed  <= c8_ff.zeroed;
      d9_ff.fx_neg  <= c8_ff.cneg ^ c8_ff.dy[DW-1];
      d9_ff.fy_neg  <= ~c8_ff.cneg ^ c8_ff.dx[DW-1];
      d9_ff.hx_neg  <= c8_ff.dx[DW-1];
      d9_ff.hy_neg  <= c8_ff.dy[DW-1];
      d9_ff.cx      <= c8_ff.cx;
      d9_ff.cy      <= c8_ff.cy;
   end

   logic         dv2_valid;
   logic [Q-1:0] dv2_quo [LANES];
   logic         dv2_ovf [LANES];
   side_d_type   dv2_side;

   lci_div_pipe #(
      .NUM_W  (NW),
      .DEN_W  (RW),
      .Q_W    (Q),
      .LANES  (LANES),
      .SIDE_W ($bits(side_d_type))
   ) u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v9_ff),
      .in_num    (num9_ff),
      .in_den    (root9_ff),
      .in_side   (d9_ff),
      .out_valid (dv2_valid),
      .out_quo   (dv2_quo),
      .out_ovf   (dv2_ovf),
      .out_side  (dv2_side)
   );

   // stage 10: signed offsets
   logic                v10_ff;
   logic signed [Q:0]   off10_ff [LANES];
   side_d_type          d10_ff;
   logic                neg_in [LANES];
   logic                keep_in [LANES];

   assign neg_in[LANE_FX]  = dv2_side.fx_neg;
   assign neg_in[LANE_FY]  = dv2_side.fy_neg;
   assign neg_in[LANE_HX]  = dv2_side.hx_neg;
   assign neg_in[LANE_HY]  = dv2_side.hy_neg;
   assign keep_in[LANE_FX] = ~dv2_side.zeroed;
   assign keep_in[LANE_FY] = ~dv2_side.zeroed;
   assign keep_in[LANE_HX] = 1'b1;
   assign keep_in[LANE_HY] = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= dv2_valid;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_off
      logic [Q-1:0]      mag_in;
      logic signed [Q:0] pos_in;

      assign mag_in = dv2_ovf[l] ? {Q{1'b1}} : dv2_quo[l];
      assign pos_in = $signed({1'b0, mag_in});

      always_ff @(posedge clock) begin
         off10_ff[l] <= !keep_in[l] ? '0 : (neg_in[l] ? -pos_in : pos_in);
      end
   end

   always_ff @(posedge clock) begin
      d10_ff <= dv2_side;
   end

   // stage 11: sum, saturate, select
   logic signed [SW-1:0] p0x_in, p0y_in, p1x_in, p1y_in;
   logic signed [SW-1:0] fxs, fys, hxs, hys;

   assign fxs    = SW'(off10_ff[LANE_FX]);
   assign fys    = SW'(off10_ff[LANE_FY]);
   assign hxs    = (d10_ff.hit == HIT_SECANT) ? SW'(off10_ff[LANE_HX]) : '0;
   assign hys    = (d10_ff.hit == HIT_SECANT) ? SW'(off10_ff[LANE_HY]) : '0;
   assign p0x_in = SW'(d10_ff.cx) + fxs + hxs;
   assign p0y_in = SW'(d10_ff.cy) + fys + hys;
   assign p1x_in = SW'(d10_ff.cx) + fxs - hxs;
   assign p1y_in = SW'(d10_ff.cy) + fys - hys;

   function automatic logic signed [W-1:0] sat_coord(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
      return W'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_count <= d10_ff.hit;
      case (d10_ff.hit)
         HIT_SECANT: begin
            rsp_point0_x <= sat_coord(p0x_in);
            rsp_point0_y <= sat_coord(p0y_in);
            rsp_point1_x <= sat_coord(p1x_in);
            rsp_point1_y <= sat_coord(p1y_in);
         end
         HIT_TANGENT: begin
            rsp_point0_x <= sat_coord(p0x_in);
            rsp_point0_y <= sat_coord(p0y_in);
            rsp_point1_x <= '0;
            rsp_point1_y <= '0;
         end
         default: begin
            rsp_point0_x <= '0;
            rsp_point0_y <= '0;
            rsp_point1_x <= '0;
            rsp_point1_y <= '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sim/line_circle_intersection_test.sv =====
// Self-checking testbench for the line and circle intersection pipeline.
module line_circle_intersection_test;
   import lci_pkg::*;

   localparam int      CW        = 32;
   localparam int      ONE       = 65536;
   localparam int      WATCHDOG  = 3000;
   localparam int      SETTLE    = 400;
   localparam longint  THRESH_SQ = (64'd1 << 32) / 10000;
   localparam longint  DIST_CAP  = 64'd1 << 62;

   typedef logic [127:0] u128_type;

   typedef struct {
      logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
      logic        [CW-2:0] r;
   } request_type;

   typedef struct {
      hit_type              count;
      logic signed [CW-1:0] p0x, p0y, p1x, p1y;
   } hits_type;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic signed [CW-1:0] req_line_a_x = 0, req_line_a_y = 0;
   logic signed [CW-1:0] req_line_b_x = 0, req_line_b_y = 0;
   logic signed [CW-1:0] req_center_x = 0, req_center_y = 0;
   logic        [CW-2:0] req_radius = 0;
   logic                 rsp_valid;
   logic        [1:0]    rsp_hit_count;
   logic signed [CW-1:0] rsp_point0_x, rsp_point0_y, rsp_point1_x, rsp_point1_y;

   hits_type pending_hits[$];
   int       mismatches = 0;
   int       idle_cycles = 0;
   bit       timed_out = 0;

   line_circle_intersection i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_line_a_x(req_line_a_x), .req_line_a_y(req_line_a_y),
      .req_line_b_x(req_line_b_x), .req_line_b_y(req_line_b_y),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_hit_count(rsp_hit_count),
      .rsp_point0_x(rsp_point0_x), .rsp_point0_y(rsp_point0_y),
      .rsp_point1_x(rsp_point1_x), .rsp_point1_y(rsp_point1_y)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] isqrt(u128_type x);
      logic [63:0] r, t;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (u128_type'(t) * u128_type'(t) <= x) r = t;
      end
      return r;
   endfunction

   function automatic logic [63:0] round_div(u128_type num, logic [63:0] root);
      u128_type q;
      q = (num + u128_type'(root >> 1)) / u128_type'(root);
      return q > u128_type'(DIST_CAP) ? DIST_CAP : q[63:0];
   endfunction

   function automatic longint scale_by(logic [63:0] a, longint b, bit neg, logic [63:0] root);
      logic [63:0] m;
      m = round_div((u128_type'(a) * u128_type'(magnitude(b))) << GUARD_BITS, root);
      return (neg ^ (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [CW-1:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[CW-1:0];
   endfunction

   // Returns 0 for a degenerate line; otherwise the line length, distance and side.
   function automatic bit line_distance(request_type q, output logic [63:0] root,
                                        output logic [63:0] dist_lsb, output bit side);
      longint           dx, dy, ox, oy;
      u128_type         len2;
      logic signed [127:0] wdx, wdy, wox, woy, cr;
      dx = longint'(q.bx) - longint'(q.ax);
      dy = longint'(q.by) - longint'(q.ay);
      ox = longint'(q.cx) - longint'(q.ax);
      oy = longint'(q.cy) - longint'(q.ay);
      len2 = u128_type'(magnitude(dx)) * u128_type'(magnitude(dx))
           + u128_type'(magnitude(dy)) * u128_type'(magnitude(dy));
      root = 0;
      dist_lsb = 0;
      side = 0;
      if (len2 <= u128_type'(THRESH_SQ)) return 0;
      root = isqrt(len2 << (2 * GUARD_BITS));
      wdx = dx; wdy = dy; wox = ox; woy = oy;
      cr = wdx * woy - wdy * wox;
      side = cr < 0;
      dist_lsb = round_div((side ? u128_type'(-cr) : u128_type'(cr)) << GUARD_BITS, root);
      return 1;
   endfunction

   function automatic hits_type predict_hits(request_type q);
      hits_type    h;
      logic [63:0] root, dist_lsb, half, r;
      bit          side, zeroed;
      longint      dx, dy, fx, fy, hx, hy, cx, cy;
      u128_type    x;
      h = '{default: 0};
      h.count = HIT_NONE;
      r = q.r;
      if (!line_distance(q, root, dist_lsb, side)) return h;
      if (dist_lsb > r + 1) return h;
      dx = longint'(q.bx) - longint'(q.ax);
      dy = longint'(q.by) - longint'(q.ay);
      cx = q.cx;
      cy = q.cy;
      fx = 0;
      fy = 0;
      zeroed = u128_type'(dist_lsb) * u128_type'(dist_lsb) <= u128_type'(THRESH_SQ);
      if (!zeroed) begin
         fx = scale_by(dist_lsb, dy, side, root);
         fy = scale_by(dist_lsb, dx, !side, root);
      end
      if ((zeroed ? 64'd0 : dist_lsb) + 1 < r) begin
         x = 0;
         if (u128_type'(r) * u128_type'(r) > u128_type'(dist_lsb) * u128_type'(dist_lsb))
            x = u128_type'(r) * u128_type'(r) - u128_type'(dist_lsb) * u128_type'(dist_lsb);
         half = isqrt(x);
         if (x > u128_type'(half) * u128_type'(half) + u128_type'(half)) half++;
         hx = scale_by(half, dx, 0, root);
         hy = scale_by(half, dy, 0, root);
         h.count = HIT_SECANT;
         h.p0x = clip(cx + fx + hx);
         h.p0y = clip(cy + fy + hy);
         h.p1x = clip(cx + fx - hx);
         h.p1y = clip(cy + fy - hy);
      end else begin
         h.count = HIT_TANGENT;
         h.p0x = clip(cx + fx);
         h.p0y = clip(cy + fy);
      end
      return h;
   endfunction

   function automatic request_type make_request(int ax, int ay, int bx, int by,
                                                int cx, int cy, logic [CW-2:0] r);
      request_type q;
      q.ax = ax; q.ay = ay; q.bx = bx; q.by = by; q.cx = cx; q.cy = cy; q.r = r;
      return q;
   endfunction

   task automatic send_request(request_type q);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_line_a_x <= q.ax;
      req_line_a_y <= q.ay;
      req_line_b_x <= q.bx;
      req_line_b_y <= q.by;
      req_center_x <= q.cx;
      req_center_y <= q.cy;
      req_radius <= q.r;
      do @(posedge clock); while (busy);
      pending_hits.push_back(predict_hits(q));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      hits_type e;
      if (!reset && rsp_valid) begin
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response count=%0d", rsp_hit_count);
         end else begin
            e = pending_hits.pop_front();
            if (rsp_hit_count !== e.count || rsp_point0_x !== e.p0x ||
                rsp_point0_y !== e.p0y || rsp_point1_x !== e.p1x ||
                rsp_point1_y !== e.p1y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d (%0d,%0d) (%0d,%0d) got %0d (%0d,%0d) (%0d,%0d)",
                           e.count, e.p0x, e.p0y, e.p1x, e.p1y, rsp_hit_count,
                           rsp_point0_x, rsp_point0_y, rsp_point1_x, rsp_point1_y);
            end
         end
      end
   end

   task automatic test_directed;
      send_request(make_request(ONE, ONE, ONE, ONE, 0, 0, 5 * ONE));
      send_request(make_request(0, 0, 300, 300, 0, 0, ONE));
      send_request(make_request(0, 0, 500, 500, 0, 0, ONE));
      send_request(make_request(0, 0, 10 * ONE, 0, 0, 3 * ONE, ONE));
      send_request(make_request(0, 0, 10 * ONE, 0, 2 * ONE, 3 * ONE, 3 * ONE));
      send_request(make_request(0, 0, 10 * ONE, 0, 2 * ONE, 3 * ONE, 3 * ONE + 1));
      send_request(make_request(0, 0, 10 * ONE, 0, 2 * ONE, 3 * ONE, 3 * ONE + 2));
      send_request(make_request(0, 0, 10 * ONE, 0, 2 * ONE, 3 * ONE, 3 * ONE - 1));
      send_request(make_request(0, 0, 10 * ONE, 0, 2 * ONE, 3 * ONE, 5 * ONE));
      send_request(make_request(-ONE, -ONE, ONE, ONE, 0, 0, 2 * ONE));
      send_request(make_request(-ONE, -ONE, ONE, ONE, 50, -50, 2 * ONE));
      send_request(make_request(-ONE, -ONE, ONE, ONE, 50, -50, 0));
      send_request(make_request(-ONE, -ONE, ONE, ONE, 0, 0, 1));
      send_request(make_request(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                0, 0, 31'h7fffffff));
      send_request(make_request(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
      send_request(make_request(0, 0, ONE, 0, 32'h7fffff00, 32'h80000000, 31'h7fffffff));
      send_request(make_request(32'h80000000, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0));
      send_request(make_request(0, 0, 0, 7, 0, 0, 31'h7fffffff));
      send_request(make_request(0, 0, 1, 0, 0, 32'h7fffffff, 31'h7fffffff));
      send_request(make_request(-1, -1, -1, -1, -1, -1, 31'h7fffffff));
   endtask

   task automatic test_random(int count);
      request_type q;
      logic [63:0] root, dist_lsb;
      bit          side;
      int          span;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               q = make_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                (CW - 1)'($urandom));
            end
            3: begin
               q.ax = $urandom_range(0, 2 * ONE) - ONE;
               q.ay = $urandom_range(0, 2 * ONE) - ONE;
               q.bx = q.ax + $urandom_range(0, 1600) - 800;
               q.by = q.ay + $urandom_range(0, 1600) - 800;
               q.cx = $urandom_range(0, 4 * ONE) - 2 * ONE;
               q.cy = $urandom_range(0, 4 * ONE) - 2 * ONE;
               q.r = (CW - 1)'($urandom_range(0, 4 * ONE));
            end
            default: begin
               span = 1 << $urandom_range(4, 24);
               q.ax = $urandom_range(0, 2 * span) - span;
               q.ay = $urandom_range(0, 2 * span) - span;
               q.bx = $urandom_range(0, 2 * span) - span;
               q.by = $urandom_range(0, 2 * span) - span;
               q.cx = $urandom_range(0, 2 * span) - span;
               q.cy = $urandom_range(0, 2 * span) - span;
               q.r = (CW - 1)'($urandom_range(0, 2 * span));
               if ($urandom_range(0, 1) && line_distance(q, root, dist_lsb, side)
                   && dist_lsb < 64'h7fff0000)
                  q.r = (CW - 1)'(dist_lsb + $urandom_range(0, 4) - 2);
            end
         endcase
         send_request(q);
      end
   endtask

   task automatic test_drain_pause;
      start <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      test_random(20);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(450);
      test_drain_pause();
      test_random(460);
      start <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_hits.size() == 0)
         $display("line_circle_intersection regression: pass");
      else
         $display("line_circle_intersection regression: fail");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG);
      timed_out = 1;
      $display("line_circle_intersection regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
src/lci_pkg.sv
src/lci_sqrt_pipe.sv
src/lci_div_pipe.sv
src/line_circle_intersection.sv
sim/line_circle_intersection_test.sv
